[src/mepd_pkg.sv]
`timescale 1ns / 1ps

package mepd_pkg;

  localparam int IN_W   = 24;
  localparam int DIFF_W = IN_W + 1;
  localparam int MAG_W  = IN_W;
  localparam int TERM_W = 2 * MAG_W;
  localparam int SUM_W  = 62;
  localparam int OUT_W  = 38;
  localparam int ROOT_W = SUM_W / 2;

  localparam logic MODE_L1 = 1'b0;
  localparam logic MODE_L2 = 1'b1;

  typedef struct packed {
    logic take;
    logic sq;
    logic add;
    logic clr;
  } acc_ctl_t;

endpackage

[src/mepd_accum.sv]
`timescale 1ns / 1ps

module mepd_accum import mepd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  acc_ctl_t                 ctl,
  input  logic signed [IN_W-1:0]   value_a,
  input  logic signed [IN_W-1:0]   value_b,
  input  logic                     mode,
  output logic        [SUM_W-1:0]  sum
);

  logic signed [DIFF_W-1:0] diff;
  logic        [MAG_W-1:0]  mag_nxt;
  logic        [MAG_W-1:0]  mag_r;
  logic                     mode_r;
  logic        [TERM_W-1:0] term_r;
  logic        [SUM_W:0]    wide_sum;
  logic        [SUM_W-1:0]  sum_r;
  logic        [SUM_W-1:0]  sum_nxt;

  assign diff    = DIFF_W'(value_a) - DIFF_W'(value_b);
  assign mag_nxt = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  assign wide_sum = {1'b0, sum_r} + (SUM_W + 1)'(term_r);

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.clr) begin
      sum_nxt = '0;
    end else if (ctl.add) begin
      sum_nxt = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      mag_r  <= mag_nxt;
      mode_r <= mode;
    end
    if (ctl.sq) begin
      term_r <= (mode_r == MODE_L2) ? mag_r * mag_r : TERM_W'(mag_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

[src/mepd_sqrt.sv]
`timescale 1ns / 1ps

module mepd_sqrt import mepd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam logic [SUM_W-1:0] BIT_TOP = SUM_W'(1) << (SUM_W - 2);
  localparam logic [SUM_W-1:0] BIT_END = SUM_W'(1);

  logic [SUM_W-1:0] n_r;
  logic [SUM_W-1:0] res_r;
  logic [SUM_W-1:0] bit_r;
  logic             busy_r;
  logic             done_r;
  logic [SUM_W-1:0] trial;
  logic             fits;

  // one restoring step per cycle
  assign trial = res_r + bit_r;
  assign fits  = n_r >= trial;

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= radicand;
      res_r <= '0;
      bit_r <= BIT_TOP;
    end else if (busy_r) begin
      if (fits) begin
        n_r   <= n_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (bit_r == BIT_END);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (bit_r == BIT_END)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

[src/manhattan_euclidean_distance.sv]
`timescale 1ns / 1ps

// L1 / L2 distance between two row vectors streamed one column pair per
// request (signed Q16.8), last marks the final column. Each column runs
// three steps: capture and |a-b|, square (L2), saturating 62-bit add. The
// last column then loads the output register in S_DONE; in L2 it first
// runs the restoring square-root step, one result bit per cycle. A result
// still held by out_stall keeps the last column waiting until it is taken.
// Result is Q.8; L1 saturates at 2^38-1. The user must see that mode is
// written only when idle; the block itself does not enforce it.
module manhattan_euclidean_distance import mepd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_mode,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [IN_W-1:0]   in_value_a,
  input  logic signed [IN_W-1:0]   in_value_b,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic        [OUT_W-1:0]  out_distance
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_ADD,
    S_START,
    S_ROOT,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              mode_r;
  logic              last_r, last_nxt;
  logic              l2_r, l2_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_distance_r, out_distance_nxt;
  acc_ctl_t          ctl;
  logic [SUM_W-1:0]  sum;
  logic              root_done;
  logic [ROOT_W-1:0] root;
  logic              take;
  logic              slot_free;
  logic [OUT_W-1:0]  l1_dist;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign take      = in_valid && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign l1_dist   = (|sum[SUM_W-1:OUT_W]) ? '1 : sum[OUT_W-1:0];

  mepd_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .value_a (in_value_a),
    .value_b (in_value_b),
    .mode    (mode_r),
    .sum     (sum)
  );

  mepd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_START),
    .radicand (sum),
    .done     (root_done),
    .root     (root)
  );

  always_comb begin
    state_nxt        = state_r;
    last_nxt         = last_r;
    l2_nxt           = l2_r;
    out_distance_nxt = out_distance_r;
    out_valid_nxt    = out_valid_r && out_stall;
    ctl              = '0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          ctl.take  = 1'b1;
          last_nxt  = in_last;
          l2_nxt    = (mode_r == MODE_L2);
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        ctl.sq    = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        ctl.add = 1'b1;
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (l2_r) begin
          state_nxt = S_START;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_START: begin
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_distance_nxt = l2_r ? OUT_W'(root) : l1_dist;
          ctl.clr          = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_L1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_mode;
      end
    end
    last_r         <= last_nxt;
    l2_r           <= l2_nxt;
    out_distance_r <= out_distance_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

endmodule
